/* hw/rtl/drs_pkg.sv */
// Disk request scheduler: shared types, codes and command/status structs.
// No dependencies; used by every other file of the block except drs_ram.
package drs_pkg;

   localparam int unsigned CYL_W  = 16;
   localparam int unsigned MOVE_W = 23;
   localparam int unsigned MODE_W = 3;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [MODE_W-1:0] MODE_FCFS  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SSTF  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SCAN  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CSCAN = 3'd3;
   localparam logic [MODE_W-1:0] MODE_LOOK  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_CLOOK = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_HEAD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_CYL   = 2'd2;

   typedef enum logic [1:0] {
      SET_ALL = 2'd0,
      SET_LO  = 2'd1,
      SET_HI  = 2'd2
   } set_type;

   typedef enum logic [1:0] {
      CRIT_FIRST = 2'd0,
      CRIT_NEAR  = 2'd1,
      CRIT_ASC   = 2'd2,
      CRIT_DESC  = 2'd3
   } crit_type;

   typedef enum logic [6:0] {
      ST_LOAD = 7'b0000001,
      ST_PRE  = 7'b0000010,
      ST_PLAN = 7'b0000100,
      ST_NEXT = 7'b0001000,
      ST_SCAN = 7'b0010000,
      ST_EMIT = 7'b0100000,
      ST_HOLD = 7'b1000000
   } state_type;

   typedef struct packed {
      logic     load;
      logic     begin_batch;
      logic     scan_start;
      logic     prescan;
      set_type  set;
      crit_type crit;
      logic     emit;
      logic     emit_ep;
      logic     ep_far;
      logic     last;
      logic     clear;
   } cmd_type;

   typedef struct packed {
      logic             scan_last;
      logic             rsp_taken;
      logic [CYL_W-1:0] min_lo;
      logic [CYL_W-1:0] max_lo;
      logic [CYL_W-1:0] min_hi;
      logic [CYL_W-1:0] max_hi;
   } status_type;

endpackage

/* hw/rtl/drs_if.sv */
// Request and result channel interfaces (valid/ready plus payload).
// Depends on drs_pkg for field widths.
interface drs_req_if;
   logic                       valid;
   logic                       ready;
   logic [drs_pkg::CYL_W-1:0]  request_cylinder;
   logic                       last_request;
   modport source (output valid, request_cylinder, last_request, input ready);
   modport sink   (input valid, request_cylinder, last_request, output ready);
endinterface

interface drs_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [drs_pkg::CYL_W-1:0]  service_cylinder;
   logic                       endpoint_visit;
   logic [drs_pkg::CYL_W-1:0]  seek_distance;
   logic [drs_pkg::MOVE_W-1:0] total_movement;
   logic                       overflow;
   logic                       last_result;
   modport source (output valid, service_cylinder, endpoint_visit, seek_distance,
                   total_movement, overflow, last_result, input ready);
   modport sink   (input valid, service_cylinder, endpoint_visit, seek_distance,
                   total_movement, overflow, last_result, output ready);
endinterface

/* hw/rtl/disk_request_scheduler.sv */
// Disk request scheduler top level: CSR registers, controller and datapath.
// Depends on drs_pkg, drs_if, drs_ctrl, drs_datapath.
//
//   port     dir   kind          contents
//   req_ch   in    valid/ready   request_cylinder, last_request
//   rsp_ch   out   valid/ready   service_cylinder, endpoint_visit, seek_distance,
//                                total_movement, overflow, last_result
//   csr_*    in    write only    index 0 mode, 1 start_head, 2 last_cylinder
//
// Each request is stored as it is accepted. On the final request, sweep modes
// first run a prescan pass to classify the N stored requests, FCFS/SSTF a single
// planning state; every request visit then runs one full pass over the store
// RAM's read port followed by emit and hold, every endpoint visit emit and hold
// only, with an extra step where the plan moves between phases, plus any wait
// for ready on the result. Requests are not taken while a batch is being
// emitted. Reset is synchronous and empties the store; there is no clearing pass.
module disk_request_scheduler #(
   parameter int unsigned MAX_REQUESTS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   drs_req_if.sink                          req_ch,
   drs_rsp_if.source                        rsp_ch,
   input  logic                             csr_we,
   input  logic [drs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [drs_pkg::CYL_W-1:0]        csr_wdata
);
   localparam int unsigned CW = $clog2(MAX_REQUESTS + 1);

   logic [drs_pkg::MODE_W-1:0] mode_ff;
   logic [drs_pkg::CYL_W-1:0]  start_head_ff, last_cyl_ff;
   logic [CW-1:0]              count, cnt_lo, cnt_hi;
   drs_pkg::cmd_type           cmd;
   drs_pkg::status_type        status;
   logic                       ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= drs_pkg::MODE_FCFS;
         start_head_ff <= 16'd2000;
         last_cyl_ff   <= 16'd4999;
      end else if (csr_we) begin
         case (csr_index)
            drs_pkg::CSR_MODE:       mode_ff       <= csr_wdata[drs_pkg::MODE_W-1:0];
            drs_pkg::CSR_START_HEAD: start_head_ff <= csr_wdata;
            drs_pkg::CSR_LAST_CYL:   last_cyl_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_ch.ready = ready;

   drs_ctrl #(.MAX_REQUESTS(MAX_REQUESTS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_last   (req_ch.last_request),
      .req_ready  (ready),
      .mode       (mode_ff),
      .start_head (start_head_ff),
      .last_cyl   (last_cyl_ff),
      .count      (count),
      .cnt_lo     (cnt_lo),
      .cnt_hi     (cnt_hi),
      .status     (status),
      .cmd        (cmd)
   );

   drs_datapath #(.MAX_REQUESTS(MAX_REQUESTS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_cyl    (req_ch.request_cylinder),
      .start_head (start_head_ff),
      .last_cyl   (last_cyl_ff),
      .count      (count),
      .cnt_lo     (cnt_lo),
      .cnt_hi     (cnt_hi),
      .rsp        (rsp_ch)
   );
endmodule

/* hw/rtl/drs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module drs_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 32
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* hw/rtl/drs_datapath.sv */
// Datapath: request store, scan engine, selection accumulators, head/sum
// tracking and the result register. Depends on drs_pkg and drs_ram.
module drs_datapath #(
   parameter int unsigned MAX_REQUESTS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  drs_pkg::cmd_type                       cmd,
   output drs_pkg::status_type                    status,
   input  logic [drs_pkg::CYL_W-1:0]              req_cyl,
   input  logic [drs_pkg::CYL_W-1:0]              start_head,
   input  logic [drs_pkg::CYL_W-1:0]              last_cyl,
   output logic [$clog2(MAX_REQUESTS + 1)-1:0]    count,
   output logic [$clog2(MAX_REQUESTS + 1)-1:0]    cnt_lo,
   output logic [$clog2(MAX_REQUESTS + 1)-1:0]    cnt_hi,
   drs_rsp_if.source                              rsp
);
   localparam int unsigned IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int unsigned CW = $clog2(MAX_REQUESTS + 1);
   localparam int unsigned YW = drs_pkg::CYL_W;
   localparam int unsigned MW = drs_pkg::MOVE_W;

   logic [CW-1:0]           count_ff;
   logic                    overflow_ff;
   logic [MAX_REQUESTS-1:0] mask_ff;
   logic [YW-1:0]           head_ff;
   logic [MW-1:0]           sum_ff;

   logic                    busy_ff, pv_ff;
   logic [IW-1:0]           rd_addr_ff, pidx_ff;
   logic                    pre_ff;
   drs_pkg::set_type        set_ff;
   drs_pkg::crit_type       crit_ff;

   logic                    found_ff;
   logic [YW-1:0]           best_v_ff, best_d_ff;
   logic [IW-1:0]           best_idx_ff;

   logic [CW-1:0]           cnt_lo_ff, cnt_hi_ff;
   logic [YW-1:0]           min_lo_ff, max_lo_ff, min_hi_ff, max_hi_ff;

   logic                    rsp_valid_ff;
   logic [YW-1:0]           o_cyl_ff, o_dist_ff;
   logic                    o_ep_ff, o_ovf_ff, o_last_ff;

   logic                    full, we;
   logic [YW-1:0]           clamped, rdata, v_dist, e_cyl, e_dist;
   logic [IW-1:0]           last_idx;
   logic                    in_lo, set_ok, better, elig;
   logic [MW-1:0]           sum_in;

   assign full     = (count_ff == CW'(MAX_REQUESTS));
   assign clamped  = (req_cyl > last_cyl) ? last_cyl : req_cyl;
   assign we       = cmd.load && !full;
   assign last_idx = IW'(count_ff - CW'(1));

   drs_ram #(.WIDTH(YW), .DEPTH(MAX_REQUESTS)) u_store (
      .clock (clock),
      .we    (we),
      .waddr (count_ff[IW-1:0]),
      .wdata (clamped),
      .raddr (rd_addr_ff),
      .rdata (rdata)
   );

   assign v_dist = (rdata > head_ff) ? (rdata - head_ff) : (head_ff - rdata);
   assign in_lo  = (rdata < start_head);

   always_comb begin
      case (set_ff)
         drs_pkg::SET_LO: set_ok = in_lo;
         drs_pkg::SET_HI: set_ok = !in_lo;
         default:         set_ok = 1'b1;
      endcase
      case (crit_ff)
         drs_pkg::CRIT_NEAR: better = !found_ff || (v_dist < best_d_ff);
         drs_pkg::CRIT_ASC:  better = !found_ff || (rdata < best_v_ff);
         drs_pkg::CRIT_DESC: better = !found_ff || (rdata > best_v_ff);
         default:            better = !found_ff;
      endcase
   end

   assign elig   = pv_ff && !pre_ff && !mask_ff[pidx_ff] && set_ok && better;
   assign e_cyl  = cmd.emit_ep ? (cmd.ep_far ? last_cyl : '0) : best_v_ff;
   assign e_dist = (e_cyl > head_ff) ? (e_cyl - head_ff) : (head_ff - e_cyl);
   assign sum_in = sum_ff + MW'(e_dist);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         mask_ff      <= '0;
         sum_ff       <= '0;
         busy_ff      <= 1'b0;
         pv_ff        <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_lo_ff    <= '0;
         cnt_hi_ff    <= '0;
      end else begin
         if (cmd.load) begin
            if (full) begin
               overflow_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + CW'(1);
            end
         end
         if (cmd.begin_batch) begin
            mask_ff <= '0;
            sum_ff  <= '0;
         end
         if (cmd.clear) begin
            count_ff    <= '0;
            overflow_ff <= 1'b0;
         end

         if (cmd.scan_start) begin
            busy_ff  <= 1'b1;
            found_ff <= 1'b0;
            if (cmd.prescan) begin
               cnt_lo_ff <= '0;
               cnt_hi_ff <= '0;
            end
         end else if (busy_ff && rd_addr_ff == last_idx) begin
            busy_ff <= 1'b0;
         end
         pv_ff <= busy_ff;

         if (pv_ff && pre_ff) begin
            if (in_lo) begin
               cnt_lo_ff <= cnt_lo_ff + CW'(1);
            end else begin
               cnt_hi_ff <= cnt_hi_ff + CW'(1);
            end
         end
         if (elig) begin
            found_ff <= 1'b1;
         end

         if (cmd.emit) begin
            sum_ff       <= sum_in;
            rsp_valid_ff <= 1'b1;
            if (!cmd.emit_ep) begin
               mask_ff[best_idx_ff] <= 1'b1;
            end
         end else if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.begin_batch) begin
         head_ff <= start_head;
      end else if (cmd.emit) begin
         head_ff <= e_cyl;
      end
      if (cmd.scan_start) begin
         rd_addr_ff <= '0;
         pre_ff     <= cmd.prescan;
         set_ff     <= cmd.set;
         crit_ff    <= cmd.crit;
      end else if (busy_ff) begin
         rd_addr_ff <= rd_addr_ff + IW'(1);
      end
      pidx_ff <= rd_addr_ff;
      if (pv_ff && pre_ff) begin
         if (in_lo) begin
            if (cnt_lo_ff == '0 || rdata < min_lo_ff) min_lo_ff <= rdata;
            if (cnt_lo_ff == '0 || rdata > max_lo_ff) max_lo_ff <= rdata;
         end else begin
            if (cnt_hi_ff == '0 || rdata < min_hi_ff) min_hi_ff <= rdata;
            if (cnt_hi_ff == '0 || rdata > max_hi_ff) max_hi_ff <= rdata;
         end
      end
      if (elig) begin
         best_v_ff   <= rdata;
         best_d_ff   <= v_dist;
         best_idx_ff <= pidx_ff;
      end
      if (cmd.emit) begin
         o_cyl_ff  <= e_cyl;
         o_dist_ff <= e_dist;
         o_ep_ff   <= cmd.emit_ep;
         o_ovf_ff  <= overflow_ff;
         o_last_ff <= cmd.last;
      end
   end

   assign status.scan_last = pv_ff && (pidx_ff == last_idx);
   assign status.rsp_taken = rsp_valid_ff && rsp.ready;
   assign status.min_lo    = min_lo_ff;
   assign status.max_lo    = max_lo_ff;
   assign status.min_hi    = min_hi_ff;
   assign status.max_hi    = max_hi_ff;

   assign count  = count_ff;
   assign cnt_lo = cnt_lo_ff;
   assign cnt_hi = cnt_hi_ff;

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.service_cylinder = o_cyl_ff;
   assign rsp.endpoint_visit   = o_ep_ff;
   assign rsp.seek_distance    = o_dist_ff;
   assign rsp.total_movement   = sum_ff;
   assign rsp.overflow         = o_ovf_ff;
   assign rsp.last_result      = o_last_ff;
endmodule

/* hw/rtl/drs_ctrl.sv */
// Controller: batch load, service plan per mode, and visit sequencing.
// Depends on drs_pkg; drives the datapath through cmd_type.
module drs_ctrl #(
   parameter int unsigned MAX_REQUESTS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_last,
   output logic                                req_ready,
   input  logic [drs_pkg::MODE_W-1:0]          mode,
   input  logic [drs_pkg::CYL_W-1:0]           start_head,
   input  logic [drs_pkg::CYL_W-1:0]           last_cyl,
   input  logic [$clog2(MAX_REQUESTS + 1)-1:0] count,
   input  logic [$clog2(MAX_REQUESTS + 1)-1:0] cnt_lo,
   input  logic [$clog2(MAX_REQUESTS + 1)-1:0] cnt_hi,
   input  drs_pkg::status_type                 status,
   output drs_pkg::cmd_type                    cmd
);
   localparam int unsigned CW = $clog2(MAX_REQUESTS + 1);
   localparam int unsigned TW = $clog2(MAX_REQUESTS + 3);

   drs_pkg::state_type state_ff, state_in;
   logic [1:0]         phase_ff, phase_in;
   logic [CW-1:0]      a_left_ff, a_left_in, b_left_ff, b_left_in;
   logic               e1_ff, e1_in, e2_ff, e2_in;
   logic               e1_far_ff, e1_far_in, e2_far_ff, e2_far_in;
   drs_pkg::set_type   a_set_ff, a_set_in, b_set_ff, b_set_in;
   drs_pkg::crit_type  a_crit_ff, a_crit_in, b_crit_ff, b_crit_in;
   logic [TW-1:0]      tot_ff, tot_in;
   logic               cur_ep_ff, cur_ep_in, cur_far_ff, cur_far_in;

   logic sweep, ends, circ, go_up, accept;

   assign sweep  = (mode == drs_pkg::MODE_SCAN) || (mode == drs_pkg::MODE_CSCAN) ||
                   (mode == drs_pkg::MODE_LOOK) || (mode == drs_pkg::MODE_CLOOK);
   assign ends   = (mode == drs_pkg::MODE_SCAN) || (mode == drs_pkg::MODE_CSCAN);
   assign circ   = (mode == drs_pkg::MODE_CSCAN) || (mode == drs_pkg::MODE_CLOOK);
   assign go_up  = (status.min_hi - start_head) < (start_head - status.max_lo);
   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == drs_pkg::ST_LOAD);

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      a_left_in  = a_left_ff;
      b_left_in  = b_left_ff;
      e1_in      = e1_ff;
      e2_in      = e2_ff;
      e1_far_in  = e1_far_ff;
      e2_far_in  = e2_far_ff;
      a_set_in   = a_set_ff;
      b_set_in   = b_set_ff;
      a_crit_in  = a_crit_ff;
      b_crit_in  = b_crit_ff;
      tot_in     = tot_ff;
      cur_ep_in  = cur_ep_ff;
      cur_far_in = cur_far_ff;
      cmd        = '0;
      cmd.set    = drs_pkg::SET_ALL;
      cmd.crit   = drs_pkg::CRIT_FIRST;

      case (state_ff)
         drs_pkg::ST_LOAD: begin
            cmd.load = accept;
            if (accept && req_last) begin
               cmd.begin_batch = 1'b1;
               if (sweep) begin
                  cmd.scan_start = 1'b1;
                  cmd.prescan    = 1'b1;
                  state_in       = drs_pkg::ST_PRE;
               end else begin
                  state_in = drs_pkg::ST_PLAN;
               end
            end
         end
         drs_pkg::ST_PRE: begin
            if (status.scan_last) state_in = drs_pkg::ST_PLAN;
         end
         drs_pkg::ST_PLAN: begin
            e1_in     = 1'b0;
            e2_in     = 1'b0;
            e1_far_in = 1'b0;
            e2_far_in = 1'b0;
            b_left_in = '0;
            b_set_in  = drs_pkg::SET_ALL;
            b_crit_in = drs_pkg::CRIT_FIRST;
            if (!sweep) begin
               a_set_in  = drs_pkg::SET_ALL;
               a_crit_in = (mode == drs_pkg::MODE_SSTF) ? drs_pkg::CRIT_NEAR
                                                        : drs_pkg::CRIT_FIRST;
               a_left_in = count;
            end else if (cnt_lo == '0) begin
               a_set_in  = drs_pkg::SET_HI;
               a_crit_in = drs_pkg::CRIT_ASC;
               a_left_in = cnt_hi;
            end else if (cnt_hi == '0) begin
               a_set_in  = drs_pkg::SET_LO;
               a_crit_in = circ ? drs_pkg::CRIT_ASC : drs_pkg::CRIT_DESC;
               a_left_in = cnt_lo;
            end else if (go_up) begin
               a_set_in  = drs_pkg::SET_HI;
               a_crit_in = drs_pkg::CRIT_ASC;
               a_left_in = cnt_hi;
               e1_in     = ends && (status.max_hi != last_cyl);
               e1_far_in = 1'b1;
               e2_in     = ends && circ && (status.min_lo != '0);
               b_set_in  = drs_pkg::SET_LO;
               b_crit_in = circ ? drs_pkg::CRIT_ASC : drs_pkg::CRIT_DESC;
               b_left_in = cnt_lo;
            end else begin
               a_set_in  = drs_pkg::SET_LO;
               a_crit_in = drs_pkg::CRIT_DESC;
               a_left_in = cnt_lo;
               e1_in     = ends && (status.min_lo != '0);
               e2_in     = ends && circ && (status.max_hi != last_cyl);
               e2_far_in = 1'b1;
               b_set_in  = drs_pkg::SET_HI;
               b_crit_in = circ ? drs_pkg::CRIT_DESC : drs_pkg::CRIT_ASC;
               b_left_in = cnt_hi;
            end
            tot_in   = TW'(a_left_in) + TW'(e1_in) + TW'(e2_in) + TW'(b_left_in);
            phase_in = 2'd0;
            state_in = drs_pkg::ST_NEXT;
         end
         drs_pkg::ST_NEXT: begin
            case (phase_ff)
               2'd0: begin
                  if (a_left_ff != '0) begin
                     a_left_in      = a_left_ff - CW'(1);
                     cmd.scan_start = 1'b1;
                     cmd.set        = a_set_ff;
                     cmd.crit       = a_crit_ff;
                     cur_ep_in      = 1'b0;
                     state_in       = drs_pkg::ST_SCAN;
                  end else begin
                     phase_in = 2'd1;
                  end
               end
               2'd1: begin
                  if (e1_ff) begin
                     e1_in      = 1'b0;
                     cur_ep_in  = 1'b1;
                     cur_far_in = e1_far_ff;
                     state_in   = drs_pkg::ST_EMIT;
                  end else begin
                     phase_in = 2'd2;
                  end
               end
               2'd2: begin
                  if (e2_ff) begin
                     e2_in      = 1'b0;
                     cur_ep_in  = 1'b1;
                     cur_far_in = e2_far_ff;
                     state_in   = drs_pkg::ST_EMIT;
                  end else begin
                     phase_in = 2'd3;
                  end
               end
               default: begin
                  if (b_left_ff != '0) begin
                     b_left_in      = b_left_ff - CW'(1);
                     cmd.scan_start = 1'b1;
                     cmd.set        = b_set_ff;
                     cmd.crit       = b_crit_ff;
                     cur_ep_in      = 1'b0;
                     state_in       = drs_pkg::ST_SCAN;
                  end
               end
            endcase
         end
         drs_pkg::ST_SCAN: begin
            if (status.scan_last) state_in = drs_pkg::ST_EMIT;
         end
         drs_pkg::ST_EMIT: begin
            cmd.emit    = 1'b1;
            cmd.emit_ep = cur_ep_ff;
            cmd.ep_far  = cur_far_ff;
            cmd.last    = (tot_ff == TW'(1));
            tot_in      = tot_ff - TW'(1);
            state_in    = drs_pkg::ST_HOLD;
         end
         drs_pkg::ST_HOLD: begin
            if (status.rsp_taken) begin
               if (tot_ff == '0) begin
                  cmd.clear = 1'b1;
                  state_in  = drs_pkg::ST_LOAD;
               end else begin
                  state_in = drs_pkg::ST_NEXT;
               end
            end
         end
         default: state_in = drs_pkg::ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= drs_pkg::ST_LOAD;
         phase_ff <= 2'd0;
         tot_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         tot_ff   <= tot_in;
      end
      a_left_ff  <= a_left_in;
      b_left_ff  <= b_left_in;
      e1_ff      <= e1_in;
      e2_ff      <= e2_in;
      e1_far_ff  <= e1_far_in;
      e2_far_ff  <= e2_far_in;
      a_set_ff   <= a_set_in;
      b_set_ff   <= b_set_in;
      a_crit_ff  <= a_crit_in;
      b_crit_ff  <= b_crit_in;
      cur_ep_ff  <= cur_ep_in;
      cur_far_ff <= cur_far_in;
   end
endmodule
